/* hw/rtl/rtza_pkg.sv */
package rtza_pkg;

	// Register indexes of the configuration channel.
	localparam logic [1:0] REG_STEP_U = 2'd0;
	localparam logic [1:0] REG_STEP_V = 2'd1;

	// Step registers: signed 8.16 held in 24 bits.
	localparam int STEP_W = 24;
	localparam int FRAC_W = 16;
	localparam logic signed [STEP_W-1:0] STEP_U_RST = 24'sh010000;
	localparam logic signed [STEP_W-1:0] STEP_V_RST = 24'sh000000;

	// Signed pixel offset from the screen middle (covers half sizes up to 512).
	localparam int D_W = 11;
	// One offset times one step.
	localparam int PROD_W = D_W + STEP_W;
	// Sum or difference of two products.
	localparam int SUM_W = PROD_W + 1;
	// Floored integer part of a rotated coordinate.
	localparam int INT_W = SUM_W - FRAC_W;

	// Non-negative value that enters the modulo unit.
	localparam int A_W = 20;
	// Shift and width of the reciprocal used for the quotient estimate.
	localparam int RCP_SH = 24;
	localparam int RCP_W = 21;
	// Quotient width: divisor is at least 16.
	localparam int Q_W = A_W - 4;
	// Wrapped texel index, up to 1023.
	localparam int IDX_W = 10;
	// Full linear address before it is cut to the port width.
	localparam int ADDR_W = 21;

	// Latency of each part, in cycles.
	localparam int ROT_LAT = 2;
	localparam int WRAP_LAT = 3;

endpackage

/* hw/rtl/rtza_rot.sv */
module rtza_rot import rtza_pkg::*; #(
	parameter int SCREEN_W = 320,
	parameter int SCREEN_H = 240
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [8:0]               pixel_x,
	input  logic [7:0]               pixel_y,
	input  logic signed [STEP_W-1:0] step_u,
	input  logic signed [STEP_W-1:0] step_v,
	output logic                     out_valid,
	output logic signed [INT_W-1:0]  u_int,
	output logic signed [INT_W-1:0]  v_int
);

	localparam logic signed [D_W-1:0] HALF_W = D_W'(SCREEN_W / 2);
	localparam logic signed [D_W-1:0] HALF_H = D_W'(SCREEN_H / 2);

	logic signed [D_W-1:0]    dx;
	logic signed [D_W-1:0]    dy;
	logic signed [PROD_W-1:0] xu_s1;
	logic signed [PROD_W-1:0] yv_s1;
	logic signed [PROD_W-1:0] xv_s1;
	logic signed [PROD_W-1:0] yu_s1;
	logic                     valid_s1;
	logic signed [SUM_W-1:0]  u_sum;
	logic signed [SUM_W-1:0]  v_sum;
	logic signed [INT_W-1:0]  u_s2;
	logic signed [INT_W-1:0]  v_s2;
	logic                     valid_s2;

	// Offsets of the pixel from the screen middle.
	assign dx = signed'({2'b00, pixel_x}) - HALF_W;
	assign dy = signed'({3'b000, pixel_y}) - HALF_H;

	// Stage 1: the four products of offsets and steps.
	always_ff @(posedge clk) begin
		xu_s1 <= PROD_W'(dx) * PROD_W'(step_u);
		yv_s1 <= PROD_W'(dy) * PROD_W'(step_v);
		xv_s1 <= PROD_W'(dx) * PROD_W'(step_v);
		yu_s1 <= PROD_W'(dy) * PROD_W'(step_u);
	end

	// Stage 2: rotate, then floor by dropping the fraction bits.
	assign u_sum = SUM_W'(xu_s1) - SUM_W'(yv_s1);
	assign v_sum = SUM_W'(xv_s1) + SUM_W'(yu_s1);

	always_ff @(posedge clk) begin
		u_s2 <= u_sum[SUM_W-1:FRAC_W];
		v_s2 <= v_sum[SUM_W-1:FRAC_W];
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign out_valid = valid_s2;
	assign u_int     = u_s2;
	assign v_int     = v_s2;

endmodule

/* hw/rtl/rtza_wrap.sv */
module rtza_wrap import rtza_pkg::*; #(
	parameter int MODULUS = 320
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic signed [INT_W-1:0] coord,
	output logic                    out_valid,
	output logic [IDX_W-1:0]        index
);

	// A multiple of the modulus that lifts every coordinate above zero.
	localparam int OFFS   = MODULUS * (((1 << 18) + MODULUS - 1) / MODULUS);
	localparam int BIAS   = MODULUS / 2 + OFFS;
	localparam int S_W    = A_W + 1;
	localparam int M_W    = A_W + RCP_W;
	localparam logic [RCP_W-1:0] RECIP = RCP_W'((1 << RCP_SH) / MODULUS);
	localparam logic [A_W-1:0]   MOD_A = A_W'(MODULUS);

	logic signed [S_W-1:0] biased;
	logic [A_W-1:0]        a_s1;
	logic                  valid_s1;
	logic [M_W-1:0]        q_full;
	logic [Q_W-1:0]        q_s2;
	logic [A_W-1:0]        a_s2;
	logic                  valid_s2;
	logic [A_W-1:0]        rem;
	logic [IDX_W-1:0]      r_s3;
	logic                  valid_s3;

	// Stage 1: add the texture centre and the lifting offset.
	assign biased = S_W'(coord) + S_W'(BIAS);

	always_ff @(posedge clk) begin
		a_s1 <= biased[A_W-1:0];
	end

	// Stage 2: quotient estimate by the reciprocal; it is exact or one low.
	assign q_full = M_W'(a_s1) * M_W'(RECIP);

	always_ff @(posedge clk) begin
		q_s2 <= q_full[RCP_SH+Q_W-1:RCP_SH];
		a_s2 <= a_s1;
	end

	// Stage 3: remainder with one correcting subtract.
	always_comb begin
		rem = a_s2 - A_W'(q_s2 * MOD_A);
		if (rem >= MOD_A) begin
			rem = rem - MOD_A;
		end
	end

	always_ff @(posedge clk) begin
		r_s3 <= rem[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign out_valid = valid_s3;
	assign index     = r_s3;

endmodule

/* hw/rtl/rotozoom_texel_address.sv */
// Channel   | Direction | Signals                                  | Handshake
// ----------+-----------+------------------------------------------+---------------------------
// pixel in  | in        | start, busy, pixel_x, pixel_y            | taken on start && !busy
// config    | in        | cfg_valid, cfg_ready, cfg_index, cfg_data| taken on cfg_valid && ready
// texel out | out       | done, texel_x, texel_y, texel_addr       | one cycle strobe on done
//
// One item enters every cycle; busy stays low, so a new pixel may follow each clock.
// Each item's result appears on done after the product and rotation registers,
// the bias, quotient and remainder stages of each axis's modulo unit, and the address register.
// Reset clears the valid bits of all stages and loads the step registers.
// The receiver cannot stall, so the pipeline never holds and nothing waits.
module rotozoom_texel_address import rtza_pkg::*; #(
	parameter int SCREEN_W = 320,
	parameter int SCREEN_H = 240,
	parameter int TEX_W    = 320,
	parameter int TEX_H    = 240
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [8:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic        done,
	output logic [8:0]  texel_x,
	output logic [7:0]  texel_y,
	output logic [16:0] texel_addr
);

	localparam int LAT = ROT_LAT + WRAP_LAT + 1;
	localparam logic [IDX_W:0] TEX_W_C = (IDX_W + 1)'(TEX_W);

	logic signed [STEP_W-1:0] step_u_q;
	logic signed [STEP_W-1:0] step_v_q;
	logic                     rot_valid;
	logic signed [INT_W-1:0]  u_int;
	logic signed [INT_W-1:0]  v_int;
	logic                     wx_valid;
	logic                     wy_valid;
	logic [IDX_W-1:0]         tx;
	logic [IDX_W-1:0]         ty;
	logic [ADDR_W-1:0]        addr_s6;
	logic [IDX_W-1:0]         tx_s6;
	logic [IDX_W-1:0]         ty_s6;
	logic                     valid_s6;

	// The pipeline never stalls.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Step registers; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_u_q <= STEP_U_RST;
			step_v_q <= STEP_V_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEP_U: step_u_q <= signed'(cfg_data);
				REG_STEP_V: step_v_q <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// Rotation and zoom about the screen middle.
	rtza_rot #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H)
	) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.step_u    (step_u_q),
		.step_v    (step_v_q),
		.out_valid (rot_valid),
		.u_int     (u_int),
		.v_int     (v_int)
	);

	// Wrap each axis into the texture.
	rtza_wrap #(
		.MODULUS (TEX_W)
	) u_wrap_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rot_valid),
		.coord     (u_int),
		.out_valid (wx_valid),
		.index     (tx)
	);

	rtza_wrap #(
		.MODULUS (TEX_H)
	) u_wrap_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rot_valid),
		.coord     (v_int),
		.out_valid (wy_valid),
		.index     (ty)
	);

	// Last stage: linear address.
	always_ff @(posedge clk) begin
		addr_s6 <= ADDR_W'(ty * TEX_W_C) + ADDR_W'(tx);
		tx_s6   <= tx;
		ty_s6   <= ty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= wx_valid && wy_valid;
		end
	end

	assign done       = valid_s6;
	assign texel_x    = tx_s6[8:0];
	assign texel_y    = ty_s6[7:0];
	assign texel_addr = addr_s6[16:0];

	// Every accepted item comes out after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item did not produce a result on time");

	// Both axis units run in lockstep.
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		wx_valid == wy_valid)
		else $error("axis wrap units out of step");

	// Wrapped indexes stay inside the texture.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (int'(tx_s6) < TEX_W) && (int'(ty_s6) < TEX_H))
		else $error("texel index outside the texture");

endmodule
